>>> hdl/mtf_pkg.sv
// Shared types and constants of the minimum-tracking queue.
package mtf_pkg;

   localparam int VALUE_W = 32;
   localparam int COUNT_W = 11;

   // Command codes carried in the kind field of an input item.
   localparam logic [1:0] KIND_ENQ = 2'd0;
   localparam logic [1:0] KIND_DEQ = 2'd1;
   localparam logic [1:0] KIND_CLR = 2'd2;
   localparam logic [1:0] KIND_QRY = 2'd3;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   typedef struct packed {
      logic [1:0]                kind;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic                      status;
      logic signed [VALUE_W-1:0] popped;
      logic signed [VALUE_W-1:0] front_value;
      logic signed [VALUE_W-1:0] min_value;
      logic [COUNT_W-1:0]        count;
      logic                      empty_res;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic enq_write;
      logic cand_pop;
      logic cand_push;
      logic deq;
      logic refresh;
      logic clear;
      logic set_err;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] kind;
      logic       full;
      logic       empty;
      logic       cand_none;
      logic       gt_cached;
      logic       gt_read;
      logic       out_free;
   } stat_type;

endpackage

>>> hdl/mtf_datapath.sv
// Datapath of the minimum-tracking queue: value store, candidate store and result register.
module mtf_datapath #(
   parameter int DEPTH = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  mtf_pkg::req_type   req_data,
   input  mtf_pkg::cmd_type   cmd,
   output mtf_pkg::stat_type  stat,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output mtf_pkg::rsp_type   rsp_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(DEPTH - 1)) begin
         return '0;
      end
      return p + PTR_W'(1);
   endfunction

   function automatic logic [PTR_W-1:0] prev_slot(input logic [PTR_W-1:0] p);
      if (p == '0) begin
         return PTR_W'(DEPTH - 1);
      end
      return p - PTR_W'(1);
   endfunction

   // Stores.
   logic signed [mtf_pkg::VALUE_W-1:0] entry_mem [DEPTH];
   logic signed [mtf_pkg::VALUE_W-1:0] cand_mem  [DEPTH];
   logic signed [mtf_pkg::VALUE_W-1:0] entry_rdata_ff;
   logic signed [mtf_pkg::VALUE_W-1:0] cand_rdata_ff;

   // Current item.
   logic [1:0]                         kind_ff;
   logic signed [mtf_pkg::VALUE_W-1:0] value_ff;
   logic                               err_ff;
   logic signed [mtf_pkg::VALUE_W-1:0] popped_ff;

   // Queue and candidate bookkeeping.
   logic [PTR_W-1:0] rp_ff, rp_in;
   logic [PTR_W-1:0] wp_ff, wp_in;
   logic [CNT_W-1:0] held_ff, held_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] ccount_ff, ccount_in;
   logic             head_moved_ff, head_moved_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Cached copies of the oldest value, the head candidate and the tail candidate.
   logic signed [mtf_pkg::VALUE_W-1:0] front_ff;
   logic signed [mtf_pkg::VALUE_W-1:0] min_ff;
   logic signed [mtf_pkg::VALUE_W-1:0] tail_val_ff;
   mtf_pkg::rsp_type                   rsp_ff;

   logic [PTR_W-1:0] rp_next;
   logic [PTR_W-1:0] head_next;
   logic [PTR_W-1:0] tail_prev;
   logic [PTR_W-1:0] cand_raddr;
   logic             head_leaves;

   assign rp_next   = next_slot(rp_ff);
   assign head_next = next_slot(head_ff);
   assign tail_prev = prev_slot(tail_ff);

   // The popped value also leaves the candidates when it is the head candidate.
   assign head_leaves = (ccount_ff != '0) && (min_ff == front_ff);

   // A tail pop reads the candidate that becomes the new tail's neighbor.
   assign cand_raddr = cmd.deq ? head_next : prev_slot(tail_prev);

   always_ff @(posedge clock) begin
      if (cmd.enq_write) begin
         entry_mem[wp_ff] <= value_ff;
      end
      if (cmd.deq) begin
         entry_rdata_ff <= entry_mem[rp_next];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cand_push) begin
         cand_mem[tail_ff] <= value_ff;
      end
      if (cmd.deq || cmd.cand_pop) begin
         cand_rdata_ff <= cand_mem[cand_raddr];
      end
   end

   always_comb begin
      rp_in         = rp_ff;
      wp_in         = wp_ff;
      held_in       = held_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      ccount_in     = ccount_ff;
      head_moved_in = head_moved_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end
      if (cmd.enq_write) begin
         wp_in   = next_slot(wp_ff);
         held_in = held_ff + CNT_W'(1);
      end
      if (cmd.cand_pop) begin
         tail_in   = tail_prev;
         ccount_in = ccount_ff - CNT_W'(1);
      end
      if (cmd.cand_push) begin
         tail_in   = next_slot(tail_ff);
         ccount_in = ccount_ff + CNT_W'(1);
      end
      if (cmd.deq) begin
         rp_in         = rp_next;
         held_in       = held_ff - CNT_W'(1);
         head_moved_in = head_leaves;
         if (head_leaves) begin
            head_in   = head_next;
            ccount_in = ccount_ff - CNT_W'(1);
         end
      end
      if (cmd.clear) begin
         rp_in     = '0;
         wp_in     = '0;
         held_in   = '0;
         head_in   = '0;
         tail_in   = '0;
         ccount_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff         <= '0;
         wp_ff         <= '0;
         held_ff       <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         ccount_ff     <= '0;
         head_moved_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rp_ff         <= rp_in;
         wp_ff         <= wp_in;
         held_ff       <= held_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         ccount_ff     <= ccount_in;
         head_moved_ff <= head_moved_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff   <= req_data.kind;
         value_ff  <= req_data.value;
         err_ff    <= mtf_pkg::STATUS_OK;
         popped_ff <= '0;
      end
      if (cmd.set_err) begin
         err_ff <= mtf_pkg::STATUS_ERR;
      end
      if (cmd.enq_write && (held_ff == '0)) begin
         front_ff <= value_ff;
      end
      if (cmd.cand_push) begin
         tail_val_ff <= value_ff;
         if (ccount_ff == '0) begin
            min_ff <= value_ff;
         end
      end
      if (cmd.deq) begin
         popped_ff <= front_ff;
      end
      if (cmd.refresh) begin
         front_ff <= entry_rdata_ff;
         if (head_moved_ff) begin
            min_ff <= cand_rdata_ff;
         end
      end
      if (cmd.emit) begin
         rsp_ff.status      <= err_ff;
         rsp_ff.popped      <= popped_ff;
         rsp_ff.front_value <= (held_ff != '0) ? front_ff : '0;
         rsp_ff.min_value   <= ((held_ff != '0) && (ccount_ff != '0)) ? min_ff : '0;
         rsp_ff.count       <= mtf_pkg::COUNT_W'(held_ff);
         rsp_ff.empty_res   <= (held_ff == '0);
      end
   end

   assign stat.kind      = kind_ff;
   assign stat.full      = (held_ff == CNT_W'(DEPTH));
   assign stat.empty     = (held_ff == '0);
   assign stat.cand_none = (ccount_ff == '0);
   assign stat.gt_cached = (tail_val_ff > value_ff);
   assign stat.gt_read   = (cand_rdata_ff > value_ff);
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> hdl/mtf_controller.sv
// Controller of the minimum-tracking queue: sequences each item through the datapath.
module mtf_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mtf_pkg::stat_type stat,
   output mtf_pkg::cmd_type  cmd
);

   typedef enum logic [1:0] {
      IDLE,
      EXEC,
      TRIM,
      FETCH
   } state_type;

   state_type state_ff, state_in;
   logic      pending_ff, pending_in;

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      pending_in = pending_ff;
      req_ready  = 1'b0;
      unique case (state_ff)
         IDLE: begin
            // A finished result moves to the output register once the register is free.
            if (pending_ff && stat.out_free) begin
               cmd.emit   = 1'b1;
               pending_in = 1'b0;
            end
            req_ready = !pending_ff || stat.out_free;
            if (req_valid && req_ready) begin
               cmd.capture = 1'b1;
               state_in    = EXEC;
            end
         end
         EXEC: begin
            unique case (stat.kind)
               mtf_pkg::KIND_ENQ: begin
                  if (stat.full) begin
                     cmd.set_err = 1'b1;
                     pending_in  = 1'b1;
                     state_in    = IDLE;
                  end else begin
                     cmd.enq_write = 1'b1;
                     if (stat.cand_none || !stat.gt_cached) begin
                        cmd.cand_push = 1'b1;
                        pending_in    = 1'b1;
                        state_in      = IDLE;
                     end else begin
                        cmd.cand_pop = 1'b1;
                        state_in     = TRIM;
                     end
                  end
               end
               mtf_pkg::KIND_DEQ: begin
                  if (stat.empty) begin
                     cmd.set_err = 1'b1;
                     pending_in  = 1'b1;
                     state_in    = IDLE;
                  end else begin
                     cmd.deq  = 1'b1;
                     state_in = FETCH;
                  end
               end
               mtf_pkg::KIND_CLR: begin
                  cmd.clear  = 1'b1;
                  pending_in = 1'b1;
                  state_in   = IDLE;
               end
               mtf_pkg::KIND_QRY: begin
                  pending_in = 1'b1;
                  state_in   = IDLE;
               end
            endcase
         end
         TRIM: begin
            // Drop tail candidates strictly greater than the new value, one per cycle.
            if (stat.cand_none || !stat.gt_read) begin
               cmd.cand_push = 1'b1;
               pending_in    = 1'b1;
               state_in      = IDLE;
            end else begin
               cmd.cand_pop = 1'b1;
            end
         end
         FETCH: begin
            cmd.refresh = 1'b1;
            pending_in  = 1'b1;
            state_in    = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= IDLE;
         pending_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pending_ff <= pending_in;
      end
   end

endmodule

>>> hdl/min_tracking_fifo.sv
// Top level of the minimum-tracking queue.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_ready  req_data  (kind, value)
//   rsp_      out        rsp_valid / rsp_ready  rsp_data  (status, popped, front_value,
//                                                          min_value, count, empty_res)
//
// One item is in work at a time. Query, clear, an item that ends in an error and an enqueue
// that removes no tail candidate pass through EXEC only; an enqueue that removes candidates
// also stays in TRIM until no greater one is left, and a dequeue passes FETCH for the store read.
// The candidate trim loop over the single-port candidate memory sets the enqueue time.
// Reset is synchronous and leaves the queue empty; no clearing pass is needed.
// A result waits in the output register while the next item is taken and worked on.
module min_tracking_fifo #(
   parameter int DEPTH = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mtf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mtf_pkg::rsp_type rsp_data
);

   mtf_pkg::cmd_type  cmd;
   mtf_pkg::stat_type stat;

   mtf_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mtf_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
